/* src/mck_pkg.sv */
// Shared types, register map and Morse pattern table for the character keyer.
// No dependencies; imported by every module of the keyer.
package mck_pkg;

   // Configuration register map
   localparam int MCK_REG_COUNT   = 3;
   localparam int MCK_ADDR_WIDTH  = 4;
   localparam int MCK_DATA_WIDTH  = 32;
   localparam int MCK_TICK_WIDTH  = 16;

   localparam logic [1:0] REG_GAP_TICKS  = 2'd0;
   localparam logic [1:0] REG_DASH_TICKS = 2'd1;
   localparam logic [1:0] REG_DOT_TICKS  = 2'd2;

   localparam logic [MCK_TICK_WIDTH-1:0] GAP_TICKS_RESET  = 16'd500;
   localparam logic [MCK_TICK_WIDTH-1:0] DASH_TICKS_RESET = 16'd700;
   localparam logic [MCK_TICK_WIDTH-1:0] DOT_TICKS_RESET  = 16'd300;

   // Depth of the queue between classifier and sequencer
   localparam int MCK_QUEUE_DEPTH = 2;

   // ASCII landmarks used by the classifier
   localparam logic [7:0] ASCII_COMMA    = 8'd44;
   localparam logic [7:0] ASCII_PERIOD   = 8'd46;
   localparam logic [7:0] ASCII_DIGIT_LO = 8'd48;
   localparam logic [7:0] ASCII_DIGIT_HI = 8'd57;
   localparam logic [7:0] ASCII_QUESTION = 8'd63;
   localparam logic [7:0] ASCII_UPPER_LO = 8'd65;
   localparam logic [7:0] ASCII_UPPER_HI = 8'd90;
   localparam logic [7:0] ASCII_LOWER_LO = 8'd97;
   localparam logic [7:0] ASCII_LOWER_HI = 8'd122;

   // Classified character: symbol count (0 = uncoded) and symbols,
   // first symbol in the MSB, 1 = dash, 0 = dot.
   typedef struct packed {
      logic [2:0] len;
      logic [5:0] sym;
      logic       eom;
   } mck_item_type;

   typedef struct packed {
      logic [2:0] len;
      logic [5:0] sym;
   } mck_pattern_type;

   // Pattern of a letter, index 0 = A
   function automatic mck_pattern_type mck_letter(input logic [4:0] idx);
      mck_pattern_type p;
      p = '0;
      case (idx)
         5'd0:  p = '{3'd2, 6'b010000}; // A .-
         5'd1:  p = '{3'd4, 6'b100000}; // B -...
         5'd2:  p = '{3'd4, 6'b101000}; // C -.-.
         5'd3:  p = '{3'd3, 6'b100000}; // D -..
         5'd4:  p = '{3'd1, 6'b000000}; // E .
         5'd5:  p = '{3'd4, 6'b001000}; // F ..-.
         5'd6:  p = '{3'd3, 6'b110000}; // G --.
         5'd7:  p = '{3'd4, 6'b000000}; // H ....
         5'd8:  p = '{3'd2, 6'b000000}; // I ..
         5'd9:  p = '{3'd4, 6'b011100}; // J .---
         5'd10: p = '{3'd3, 6'b101000}; // K -.-
         5'd11: p = '{3'd4, 6'b010000}; // L .-..
         5'd12: p = '{3'd2, 6'b110000}; // M --
         5'd13: p = '{3'd2, 6'b100000}; // N -.
         5'd14: p = '{3'd3, 6'b111000}; // O ---
         5'd15: p = '{3'd4, 6'b011000}; // P .--.
         5'd16: p = '{3'd4, 6'b110100}; // Q --.-
         5'd17: p = '{3'd3, 6'b010000}; // R .-.
         5'd18: p = '{3'd3, 6'b000000}; // S ...
         5'd19: p = '{3'd1, 6'b100000}; // T -
         5'd20: p = '{3'd3, 6'b001000}; // U ..-
         5'd21: p = '{3'd4, 6'b000100}; // V ...-
         5'd22: p = '{3'd3, 6'b011000}; // W .--
         5'd23: p = '{3'd4, 6'b100100}; // X -..-
         5'd24: p = '{3'd4, 6'b101100}; // Y -.--
         5'd25: p = '{3'd4, 6'b110000}; // Z --..
         default: p = '0;
      endcase
      return p;
   endfunction

   // Pattern of a digit 0..9
   function automatic mck_pattern_type mck_digit(input logic [3:0] idx);
      mck_pattern_type p;
      p = '0;
      case (idx)
         4'd0: p = '{3'd5, 6'b111110};
         4'd1: p = '{3'd5, 6'b011110};
         4'd2: p = '{3'd5, 6'b001110};
         4'd3: p = '{3'd5, 6'b000110};
         4'd4: p = '{3'd5, 6'b000010};
         4'd5: p = '{3'd5, 6'b000000};
         4'd6: p = '{3'd5, 6'b100000};
         4'd7: p = '{3'd5, 6'b110000};
         4'd8: p = '{3'd5, 6'b111000};
         4'd9: p = '{3'd5, 6'b111100};
         default: p = '0;
      endcase
      return p;
   endfunction

   // Full classifier: byte to pattern, uncoded bytes give length zero
   function automatic mck_pattern_type mck_classify(input logic [7:0] c);
      mck_pattern_type p;
      logic [7:0]      off;
      p   = '0;
      off = '0;
      if (c >= ASCII_LOWER_LO && c <= ASCII_LOWER_HI) begin
         off = c - ASCII_LOWER_LO;
         p   = mck_letter(off[4:0]);
      end else if (c >= ASCII_UPPER_LO && c <= ASCII_UPPER_HI) begin
         off = c - ASCII_UPPER_LO;
         p   = mck_letter(off[4:0]);
      end else if (c >= ASCII_DIGIT_LO && c <= ASCII_DIGIT_HI) begin
         off = c - ASCII_DIGIT_LO;
         p   = mck_digit(off[3:0]);
      end else if (c == ASCII_QUESTION) begin
         p = '{3'd6, 6'b001100};
      end else if (c == ASCII_PERIOD) begin
         p = '{3'd6, 6'b010101};
      end else if (c == ASCII_COMMA) begin
         p = '{3'd6, 6'b110011};
      end
      return p;
   endfunction

endpackage

/* src/morse_character_keyer.sv */
// Top level of the Morse character keyer: register file, front end, queue, sequencer.
// Depends on mck_pkg, mck_front, mck_queue and mck_back.
//
//   channel   direction  handshake             payload
//   request   in         push / full           req_ascii_char, req_end_of_message
//   response  out        empty / pop           rsp_led_on, rsp_duration,
//                                              rsp_char_last, rsp_message_end
//   csr       in/out     psel/penable/pready   paddr, pwdata, prdata (gap, dash, dot)
//
// A coded character of n symbols gives 2n segments, one per cycle while the
// result side keeps popping, after the sequencer has loaded it from the queue;
// an uncoded byte gives one dark segment. The rate is set by the sequencer,
// which emits one segment a cycle into a one-entry output register.
// Requests queue up (QueueDepth entries) while a character is being sent.
// Synchronous reset clears control state and loads the register defaults.
module morse_character_keyer
   import mck_pkg::*;
#(
   parameter int QueueDepth = MCK_QUEUE_DEPTH
)(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic [7:0]                req_ascii_char,
   input  logic                      req_end_of_message,
   output logic                      empty,
   input  logic                      pop,
   output logic                      rsp_led_on,
   output logic [MCK_TICK_WIDTH-1:0] rsp_duration,
   output logic                      rsp_char_last,
   output logic                      rsp_message_end,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [MCK_ADDR_WIDTH-1:0] paddr,
   input  logic [MCK_DATA_WIDTH-1:0] pwdata,
   output logic [MCK_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   logic [MCK_TICK_WIDTH-1:0] gap_ticks_ff, gap_ticks_in;
   logic [MCK_TICK_WIDTH-1:0] dash_ticks_ff, dash_ticks_in;
   logic [MCK_TICK_WIDTH-1:0] dot_ticks_ff, dot_ticks_in;
   logic [1:0]                reg_idx;
   logic                      csr_write;
   logic                      q_push, q_pop, q_full, q_empty;
   mck_item_type              q_push_item, q_pop_item;

   assign pready    = 1'b1;
   assign reg_idx   = paddr[3:2];
   assign csr_write = psel & penable & pwrite & pready;

   // Register writes; unmapped addresses are ignored
   always_comb begin
      gap_ticks_in  = gap_ticks_ff;
      dash_ticks_in = dash_ticks_ff;
      dot_ticks_in  = dot_ticks_ff;
      if (csr_write) begin
         unique case (reg_idx)
            REG_GAP_TICKS:  gap_ticks_in  = pwdata[MCK_TICK_WIDTH-1:0];
            REG_DASH_TICKS: dash_ticks_in = pwdata[MCK_TICK_WIDTH-1:0];
            REG_DOT_TICKS:  dot_ticks_in  = pwdata[MCK_TICK_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Register read mux
   always_comb begin
      unique case (reg_idx)
         REG_GAP_TICKS:  prdata = MCK_DATA_WIDTH'(gap_ticks_ff);
         REG_DASH_TICKS: prdata = MCK_DATA_WIDTH'(dash_ticks_ff);
         REG_DOT_TICKS:  prdata = MCK_DATA_WIDTH'(dot_ticks_ff);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ticks_ff  <= GAP_TICKS_RESET;
         dash_ticks_ff <= DASH_TICKS_RESET;
         dot_ticks_ff  <= DOT_TICKS_RESET;
      end else begin
         gap_ticks_ff  <= gap_ticks_in;
         dash_ticks_ff <= dash_ticks_in;
         dot_ticks_ff  <= dot_ticks_in;
      end
   end

   assign full = q_full;

   mck_front u_front (
      .push               (push),
      .req_ascii_char     (req_ascii_char),
      .req_end_of_message (req_end_of_message),
      .queue_full         (q_full),
      .queue_push         (q_push),
      .queue_item         (q_push_item)
   );

   mck_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_item  (q_pop_item)
   );

   mck_back u_back (
      .clock           (clock),
      .reset           (reset),
      .gap_ticks       (gap_ticks_ff),
      .dash_ticks      (dash_ticks_ff),
      .dot_ticks       (dot_ticks_ff),
      .item_empty      (q_empty),
      .item            (q_pop_item),
      .item_pop        (q_pop),
      .empty           (empty),
      .pop             (pop),
      .rsp_led_on      (rsp_led_on),
      .rsp_duration    (rsp_duration),
      .rsp_char_last   (rsp_char_last),
      .rsp_message_end (rsp_message_end)
   );

   // Checks
   a_reset_empty: assert property (@(posedge clock)
      reset |=> empty)
      else $error("response valid right after reset");

   a_mend_on_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_message_end) |-> rsp_char_last)
      else $error("message end flagged on a segment that is not last");

   a_uncoded_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_led_on && rsp_char_last) |-> (rsp_duration == '0))
      else $error("final dark segment with nonzero duration");

   a_mark_duration: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_led_on) |->
         (rsp_duration == dash_ticks_ff || rsp_duration == dot_ticks_ff))
      else $error("lit segment duration is neither dot nor dash");

endmodule

/* src/mck_front.sv */
// Front end: accepts a character request and classifies it into a Morse pattern.
// Depends on mck_pkg.
module mck_front
   import mck_pkg::*;
(
   input  logic         push,
   input  logic [7:0]   req_ascii_char,
   input  logic         req_end_of_message,
   input  logic         queue_full,
   output logic         queue_push,
   output mck_item_type queue_item
);

   mck_pattern_type pattern;

   // Table lookup, then hand the item to the queue
   always_comb begin
      pattern          = mck_classify(req_ascii_char);
      queue_item.len   = pattern.len;
      queue_item.sym   = pattern.sym;
      queue_item.eom   = req_end_of_message;
      queue_push       = push & ~queue_full;
   end

endmodule

/* src/mck_queue.sv */
// Small FIFO of classified characters between front end and sequencer.
// Depends on mck_pkg.
module mck_queue
   import mck_pkg::*;
#(
   parameter int Depth = MCK_QUEUE_DEPTH
)(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  mck_item_type push_item,
   output logic         full,
   input  logic         pop,
   output logic         empty,
   output mck_item_type pop_item
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   mck_item_type      store_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == CntW'(Depth));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_item = store_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* src/mck_back.sv */
// Back end: walks a character's symbols and emits gap/mark LED segments.
// Depends on mck_pkg; fed by mck_queue, drives the result output register.
module mck_back
   import mck_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic [MCK_TICK_WIDTH-1:0] gap_ticks,
   input  logic [MCK_TICK_WIDTH-1:0] dash_ticks,
   input  logic [MCK_TICK_WIDTH-1:0] dot_ticks,
   input  logic                      item_empty,
   input  mck_item_type              item,
   output logic                      item_pop,
   output logic                      empty,
   input  logic                      pop,
   output logic                      rsp_led_on,
   output logic [MCK_TICK_WIDTH-1:0] rsp_duration,
   output logic                      rsp_char_last,
   output logic                      rsp_message_end
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_GAP  = 3'b010,
      ST_MARK = 3'b100
   } state_type;

   state_type                 state_ff, state_in;
   logic [2:0]                left_ff, left_in;
   logic [5:0]                sym_ff, sym_in;
   logic                      eom_ff, eom_in;
   logic                      out_valid_ff, out_valid_in;
   logic                      led_ff, led_in;
   logic [MCK_TICK_WIDTH-1:0] dur_ff, dur_in;
   logic                      last_ff, last_in;
   logic                      mend_ff, mend_in;
   logic                      slot_free;

   // Output slot can take a segment when empty or being drained
   assign slot_free = ~out_valid_ff | pop;

   assign empty           = ~out_valid_ff;
   assign rsp_led_on      = led_ff;
   assign rsp_duration    = dur_ff;
   assign rsp_char_last   = last_ff;
   assign rsp_message_end = mend_ff;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      left_in      = left_ff;
      sym_in       = sym_ff;
      eom_in       = eom_ff;
      out_valid_in = out_valid_ff & ~pop;
      led_in       = led_ff;
      dur_in       = dur_ff;
      last_in      = last_ff;
      mend_in      = mend_ff;
      item_pop     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!item_empty) begin
               item_pop = 1'b1;
               left_in  = item.len;
               sym_in   = item.sym;
               eom_in   = item.eom;
               state_in = ST_GAP;
            end
         end
         ST_GAP: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               led_in       = 1'b0;
               if (left_ff == '0) begin
                  // uncoded byte: one empty dark segment
                  dur_in   = '0;
                  last_in  = 1'b1;
                  mend_in  = eom_ff;
                  state_in = ST_IDLE;
               end else begin
                  dur_in   = gap_ticks;
                  last_in  = 1'b0;
                  mend_in  = 1'b0;
                  state_in = ST_MARK;
               end
            end
         end
         ST_MARK: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               led_in       = 1'b1;
               dur_in       = sym_ff[5] ? dash_ticks : dot_ticks;
               last_in      = (left_ff == 3'd1);
               mend_in      = (left_ff == 3'd1) & eom_ff;
               sym_in       = {sym_ff[4:0], 1'b0};
               left_in      = left_ff - 1'b1;
               state_in     = (left_ff == 3'd1) ? ST_IDLE : ST_GAP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      left_ff <= left_in;
      sym_ff  <= sym_in;
      eom_ff  <= eom_in;
      led_ff  <= led_in;
      dur_ff  <= dur_in;
      last_ff <= last_in;
      mend_ff <= mend_in;
   end

endmodule

/* tb/morse_segment_checker.sv */
// Segment checker for the Morse character keyer: watches the request, response
// and register channels, predicts LED segments and compares them in order.
// Depends on mck_pkg for the register map and ASCII landmarks.
module morse_segment_checker
   import mck_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic                      full,
   input  logic [7:0]                req_ascii_char,
   input  logic                      req_end_of_message,
   input  logic                      empty,
   input  logic                      pop,
   input  logic                      rsp_led_on,
   input  logic [MCK_TICK_WIDTH-1:0] rsp_duration,
   input  logic                      rsp_char_last,
   input  logic                      rsp_message_end,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [MCK_ADDR_WIDTH-1:0] paddr,
   input  logic [MCK_DATA_WIDTH-1:0] pwdata,
   input  logic                      pready,
   output int                        mismatch_count,
   output int                        segments_pending,
   output int                        segments_compared
);
   timeunit 1ns;
   timeprecision 1ps;

   // Timing defaults after reset
   localparam logic [15:0] GAP_DEFAULT  = 16'd500;
   localparam logic [15:0] DASH_DEFAULT = 16'd700;
   localparam logic [15:0] DOT_DEFAULT  = 16'd300;

   typedef struct packed {
      logic        led_on;
      logic [15:0] duration;
      logic        char_last;
      logic        message_end;
   } keyer_segment_type;

   logic [15:0]       gap_ticks;
   logic [15:0]       dash_ticks;
   logic [15:0]       dot_ticks;
   keyer_segment_type pending_segments [$];

   // Dots and dashes for one byte; empty string when the byte has no code
   function automatic string morse_symbols(input logic [7:0] ch);
      logic [7:0] folded;
      folded = ch;
      if (ch >= ASCII_UPPER_LO && ch <= ASCII_UPPER_HI)
         folded = ch + (ASCII_LOWER_LO - ASCII_UPPER_LO);
      case (folded)
         "a": return ".-";
         "b": return "-...";
         "c": return "-.-.";
         "d": return "-..";
         "e": return ".";
         "f": return "..-.";
         "g": return "--.";
         "h": return "....";
         "i": return "..";
         "j": return ".---";
         "k": return "-.-";
         "l": return ".-..";
         "m": return "--";
         "n": return "-.";
         "o": return "---";
         "p": return ".--.";
         "q": return "--.-";
         "r": return ".-.";
         "s": return "...";
         "t": return "-";
         "u": return "..-";
         "v": return "...-";
         "w": return ".--";
         "x": return "-..-";
         "y": return "-.--";
         "z": return "--..";
         "0": return "-----";
         "1": return ".----";
         "2": return "..---";
         "3": return "...--";
         "4": return "....-";
         "5": return ".....";
         "6": return "-....";
         "7": return "--...";
         "8": return "---..";
         "9": return "----.";
         ",": return "--..--";
         ".": return ".-.-.-";
         "?": return "..--..";
         default: return "";
      endcase
   endfunction

   always @(posedge clock) begin : watch
      string             symbols;
      keyer_segment_type seg;
      keyer_segment_type want;
      logic              last_symbol;
      if (reset) begin
         gap_ticks  = GAP_DEFAULT;
         dash_ticks = DASH_DEFAULT;
         dot_ticks  = DOT_DEFAULT;
         pending_segments.delete();
         mismatch_count    = 0;
         segments_compared = 0;
      end else begin
         // register writes; unmapped addresses are ignored
         if (psel && penable && pwrite && pready) begin
            case (paddr[MCK_ADDR_WIDTH-1:2])
               REG_GAP_TICKS:  gap_ticks  = pwdata[15:0];
               REG_DASH_TICKS: dash_ticks = pwdata[15:0];
               REG_DOT_TICKS:  dot_ticks  = pwdata[15:0];
               default: ;
            endcase
         end

         // accepted request: expand into off/on segment pairs, or one dark segment for an uncoded byte
         if (push && !full) begin
            symbols = morse_symbols(req_ascii_char);
            if (symbols.len() == 0) begin
               seg = '{1'b0, 16'd0, 1'b1, req_end_of_message};
               pending_segments.push_back(seg);
            end else begin
               for (int i = 0; i < symbols.len(); i++) begin
                  last_symbol = (i == symbols.len() - 1);
                  seg = '{1'b0, gap_ticks, 1'b0, 1'b0};
                  pending_segments.push_back(seg);
                  seg = '{1'b1, (symbols[i] == "-") ? dash_ticks : dot_ticks,
                          last_symbol, last_symbol & req_end_of_message};
                  pending_segments.push_back(seg);
               end
            end
         end

         // accepted segment: compare with the oldest prediction
         if (pop && !empty) begin
            if (pending_segments.size() == 0) begin
               $error("unexpected segment: led_on=%0d duration=%0d char_last=%0d message_end=%0d",
                      rsp_led_on, rsp_duration, rsp_char_last, rsp_message_end);
               mismatch_count++;
            end else begin
               want = pending_segments.pop_front();
               segments_compared++;
               if (rsp_led_on !== want.led_on) begin
                  $error("led_on mismatch: expected %0d, got %0d", want.led_on, rsp_led_on);
                  mismatch_count++;
               end
               if (rsp_duration !== want.duration) begin
                  $error("duration mismatch: expected %0d, got %0d",
                         want.duration, rsp_duration);
                  mismatch_count++;
               end
               if (rsp_char_last !== want.char_last) begin
                  $error("char_last mismatch: expected %0d, got %0d",
                         want.char_last, rsp_char_last);
                  mismatch_count++;
               end
               if (rsp_message_end !== want.message_end) begin
                  $error("message_end mismatch: expected %0d, got %0d",
                         want.message_end, rsp_message_end);
                  mismatch_count++;
               end
            end
         end
      end
      segments_pending = pending_segments.size();
   end

endmodule

/* tb/testbench.sv */
// Top of the keyer testbench: clock, reset, request and response traffic,
// timing register writes, watchdog and verdict.
// Depends on mck_pkg, morse_character_keyer and morse_segment_checker.
module testbench;
   import mck_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          PHASE_COUNT     = 8;
   localparam int          RANDOM_PER_PHASE = 25;
   localparam int          HOLD_OFF_CYCLES = 300;
   localparam int          WATCHDOG_LIMIT  = 2000;
   localparam int          DRAIN_CYCLES    = 20;
   localparam logic [1:0]  REG_UNMAPPED    = 2'd3;

   // Edge bytes: every class boundary, one neighbor of each, and the byte extremes
   localparam logic [7:0] DIRECTED_CHARS [23] = '{
      8'h00, 8'hFF, ASCII_LOWER_LO, ASCII_LOWER_HI, ASCII_UPPER_LO, ASCII_UPPER_HI,
      ASCII_DIGIT_LO, ASCII_DIGIT_HI, ASCII_COMMA, ASCII_PERIOD, ASCII_QUESTION,
      ASCII_UPPER_LO - 8'd1, ASCII_UPPER_HI + 8'd1, ASCII_LOWER_LO - 8'd1,
      ASCII_LOWER_HI + 8'd1, ASCII_DIGIT_LO - 8'd1, ASCII_DIGIT_HI + 8'd1,
      ASCII_QUESTION - 8'd1, ASCII_PERIOD - 8'd1, ASCII_COMMA - 8'd1,
      8'h7F, 8'h80, "e"
   };

   logic                      clock;
   logic                      reset;
   logic                      push;
   logic                      full;
   logic [7:0]                req_ascii_char;
   logic                      req_end_of_message;
   logic                      empty;
   logic                      pop;
   logic                      rsp_led_on;
   logic [MCK_TICK_WIDTH-1:0] rsp_duration;
   logic                      rsp_char_last;
   logic                      rsp_message_end;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [MCK_ADDR_WIDTH-1:0] paddr;
   logic [MCK_DATA_WIDTH-1:0] pwdata;
   logic [MCK_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   int mismatch_count;
   int segments_pending;
   int segments_compared;
   int requests_sent;
   int sender_idle_pct;
   int receiver_stall_pct;
   bit hold_off_request;
   int quiet_cycles;

   morse_character_keyer dut (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_ascii_char     (req_ascii_char),
      .req_end_of_message (req_end_of_message),
      .empty              (empty),
      .pop                (pop),
      .rsp_led_on         (rsp_led_on),
      .rsp_duration       (rsp_duration),
      .rsp_char_last      (rsp_char_last),
      .rsp_message_end    (rsp_message_end),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   morse_segment_checker segment_check (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_ascii_char     (req_ascii_char),
      .req_end_of_message (req_end_of_message),
      .empty              (empty),
      .pop                (pop),
      .rsp_led_on         (rsp_led_on),
      .rsp_duration       (rsp_duration),
      .rsp_char_last      (rsp_char_last),
      .rsp_message_end    (rsp_message_end),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .pready             (pready),
      .mismatch_count     (mismatch_count),
      .segments_pending   (segments_pending),
      .segments_compared  (segments_compared)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Response side: random stalls, plus one long hold-off on request
   initial begin
      pop = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            pop <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else begin
            pop <= ($urandom_range(99) >= receiver_stall_pct);
            @(negedge clock);
         end
      end
   end

   // Watchdog: ends the run after too long without any handshake
   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((push && !full) || (pop && !empty) || (psel && penable))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("FAILED: results differ");
      $finish;
   end

   // One request; starts and ends at a falling edge, leaves push high
   task automatic send_char(input logic [7:0] ch, input logic eom);
      while ($urandom_range(99) < sender_idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push               <= 1'b1;
      req_ascii_char     <= ch;
      req_end_of_message <= eom;
      do @(posedge clock); while (full);
      @(negedge clock);
      requests_sent++;
   endtask

   task automatic wait_for_drain();
      push <= 1'b0;
      while (segments_pending != 0) @(negedge clock);
   endtask

   // Register write: setup then access; psel stays up for back-to-back writes
   task automatic csr_write(input logic [1:0] index, input logic [15:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= MCK_ADDR_WIDTH'({index, 2'b00});
      pwdata  <= {16'($urandom), value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
   endtask

   task automatic apply_timing(input logic [15:0] gap, input logic [15:0] dash,
                               input logic [15:0] dot, input bit poke_unmapped);
      csr_write(REG_GAP_TICKS, gap);
      csr_write(REG_DASH_TICKS, dash);
      if (poke_unmapped)
         csr_write(REG_UNMAPPED, 16'($urandom));
      csr_write(REG_DOT_TICKS, dot);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   initial begin
      logic [15:0] gap;
      logic [15:0] dash;
      logic [15:0] dot;
      logic [7:0]  ch;
      int          roll;

      reset              = 1'b1;
      push               = 1'b0;
      req_ascii_char     = 8'h00;
      req_end_of_message = 1'b0;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_off_request   = 1'b0;
      requests_sent      = 0;

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Directed edge bytes under the reset timing
      foreach (DIRECTED_CHARS[i])
         send_char(DIRECTED_CHARS[i], i[0]);
      wait_for_drain();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         // Timing setting for this phase, extremes included
         case (phase)
            0: begin gap = 16'h0000; dash = 16'h0000; dot = 16'h0000; end
            1: begin gap = 16'hFFFF; dash = 16'hFFFF; dot = 16'hFFFF; end
            2: begin gap = 16'h5555; dash = 16'hAAAA; dot = 16'h0001; end
            5: begin gap = 16'h0000; dash = 16'hFFFF; dot = 16'h0001; end
            7: begin gap = 16'hFFFF; dash = 16'h0000; dot = 16'h7FFF; end
            default: begin
               gap  = 16'($urandom);
               dash = 16'($urandom);
               dot  = 16'($urandom);
            end
         endcase
         apply_timing(gap, dash, dot, phase == 2);

         // Idle mode: none, sender, receiver, both
         case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 50; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 50; end
            default: begin sender_idle_pct = 37; receiver_stall_pct = 37; end
         endcase
         if (phase % 4 == 0)
            hold_off_request = 1'b1;

         // Mostly well-formed text, some arbitrary bytes
         repeat (RANDOM_PER_PHASE) begin
            roll = $urandom_range(99);
            if (roll < 40)
               ch = 8'($urandom_range(ASCII_LOWER_LO, ASCII_LOWER_HI));
            else if (roll < 60)
               ch = 8'($urandom_range(ASCII_UPPER_LO, ASCII_UPPER_HI));
            else if (roll < 72)
               ch = 8'($urandom_range(ASCII_DIGIT_LO, ASCII_DIGIT_HI));
            else if (roll < 76)
               ch = ASCII_COMMA;
            else if (roll < 80)
               ch = ASCII_PERIOD;
            else if (roll < 84)
               ch = ASCII_QUESTION;
            else
               ch = 8'($urandom_range(255));
            send_char(ch, $urandom_range(3) == 0);
         end
         wait_for_drain();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Coverage: %0d requests (edge bytes, then text under %0d timing settings)",
               requests_sent, PHASE_COUNT);
      $display("Compared %0d segments across no-idle, sender, receiver and mixed stalls",
               segments_compared);
      if (mismatch_count == 0 && segments_pending == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
